// ----- hw/rtl/srchk_pkg.sv -----
// ----------------------------------------------------------------------------
// srchk_pkg: shared types and constants for the IPv4 source-route check
// Option codes, verdict codes, scan phases and the scan state record.
// ----------------------------------------------------------------------------
package srchk_pkg;

  localparam int MAX_OPTION_BYTES = 40;

  localparam int BYTE_W = 8;
  localparam int LEFT_W = 6;

  // Option type codes
  localparam logic [BYTE_W-1:0] OPT_END  = 8'd0;
  localparam logic [BYTE_W-1:0] OPT_NOOP = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_LSRR = 8'd131;
  localparam logic [BYTE_W-1:0] OPT_SSRR = 8'd137;

  // Option field limits
  localparam logic [BYTE_W-1:0] MIN_OPT_LEN  = 8'd2;
  localparam logic [BYTE_W-1:0] MIN_SR_LEN   = 8'd3;
  localparam logic [BYTE_W-1:0] MIN_SR_PTR   = 8'd4;
  localparam logic [BYTE_W-1:0] SR_ADDR_ROOM = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_SRFAIL  = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PTR  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   option_length;
    logic [BYTE_W-1:0]   bytes_into_option;
    logic                is_source_route;
    logic                verdict_given;
  } state_t;

  typedef struct packed {
    logic     hit;
    verdict_t verdict;
  } step_res_t;

  localparam state_t STATE_RESET = '{
    phase:             PH_TYPE,
    option_length:     '0,
    bytes_into_option: '0,
    is_source_route:   1'b0,
    verdict_given:     1'b0
  };

endpackage

// ----- hw/rtl/srchk_if.sv -----
// ----------------------------------------------------------------------------
// srchk_if: valid/ready channels of the source-route check
// Input channel carries one options byte with its remaining count; output
// channel carries one verdict.
// ----------------------------------------------------------------------------
interface srchk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic [5:0] bytes_left;

  modport source (output valid, output opt_byte, output bytes_left, input ready);
  modport sink   (input valid, input opt_byte, input bytes_left, output ready);
endinterface

interface srchk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ----- hw/rtl/srchk_eval.sv -----
// ----------------------------------------------------------------------------
// srchk_eval: one scan step of the options area
// Judge one byte against the current scan state; give the next state and
// an optional verdict.
// ----------------------------------------------------------------------------
module srchk_eval #(
  parameter int MaxOptionBytes = srchk_pkg::MAX_OPTION_BYTES
) (
  input  srchk_pkg::state_t    st,
  input  logic [7:0]           opt_byte,
  input  logic [5:0]           bytes_left,
  output srchk_pkg::state_t    st_next,
  output srchk_pkg::step_res_t res
);

  logic [5:0] left_c;
  logic       last;
  logic [8:0] len_limit;
  logic [7:0] bio_inc;

  // Zero counts as the last byte; large counts saturate
  always_comb begin
    if (bytes_left == 6'd0) begin
      left_c = 6'd1;
    end else if (bytes_left > 6'(MaxOptionBytes)) begin
      left_c = 6'(MaxOptionBytes);
    end else begin
      left_c = bytes_left;
    end
  end

  assign last      = (left_c == 6'd1);
  assign len_limit = {3'b000, left_c} + 9'd1;
  assign bio_inc   = st.bytes_into_option + 8'd1;

  always_comb begin
    st_next     = st;
    res.hit     = 1'b0;
    res.verdict = srchk_pkg::VERDICT_PASS;
    if (st.verdict_given) begin
      if (last) begin
        st_next = srchk_pkg::STATE_RESET;
      end
    end else begin
      unique case (st.phase)
        srchk_pkg::PH_TYPE: begin
          if (opt_byte == srchk_pkg::OPT_END) begin
            res.hit = 1'b1;
          end else if (opt_byte != srchk_pkg::OPT_NOOP) begin
            if (left_c < 6'd2) begin
              res.hit     = 1'b1;
              res.verdict = srchk_pkg::VERDICT_INVALID;
            end else begin
              st_next.is_source_route = (opt_byte == srchk_pkg::OPT_LSRR) ||
                                        (opt_byte == srchk_pkg::OPT_SSRR);
              st_next.bytes_into_option = 8'd1;
              st_next.phase             = srchk_pkg::PH_LEN;
            end
          end
        end
        srchk_pkg::PH_LEN: begin
          st_next.option_length = opt_byte;
          if (opt_byte < srchk_pkg::MIN_OPT_LEN || {1'b0, opt_byte} > len_limit) begin
            res.hit     = 1'b1;
            res.verdict = srchk_pkg::VERDICT_INVALID;
          end else if (st.is_source_route) begin
            if (opt_byte < srchk_pkg::MIN_SR_LEN) begin
              res.hit     = 1'b1;
              res.verdict = srchk_pkg::VERDICT_INVALID;
            end else begin
              st_next.bytes_into_option = 8'd2;
              st_next.phase             = srchk_pkg::PH_PTR;
            end
          end else if (opt_byte == srchk_pkg::MIN_OPT_LEN) begin
            st_next.bytes_into_option = 8'd0;
            st_next.phase             = srchk_pkg::PH_TYPE;
          end else begin
            st_next.bytes_into_option = 8'd2;
            st_next.phase             = srchk_pkg::PH_SKIP;
          end
        end
        srchk_pkg::PH_PTR: begin
          res.hit = 1'b1;
          // length is at least three here, so the subtract cannot wrap
          if (opt_byte < srchk_pkg::MIN_SR_PTR) begin
            res.verdict = srchk_pkg::VERDICT_INVALID;
          end else if (opt_byte > st.option_length) begin
            res.verdict = srchk_pkg::VERDICT_PASS;
          end else if (opt_byte > st.option_length - srchk_pkg::SR_ADDR_ROOM) begin
            res.verdict = srchk_pkg::VERDICT_INVALID;
          end else begin
            res.verdict = srchk_pkg::VERDICT_SRFAIL;
          end
        end
        srchk_pkg::PH_SKIP: begin
          if (bio_inc >= st.option_length) begin
            st_next.bytes_into_option = 8'd0;
            st_next.phase             = srchk_pkg::PH_TYPE;
          end else begin
            st_next.bytes_into_option = bio_inc;
          end
        end
        default: begin
          st_next = srchk_pkg::STATE_RESET;
        end
      endcase

      // End of area with no decision passes
      if (!res.hit && last) begin
        res.hit     = 1'b1;
        res.verdict = srchk_pkg::VERDICT_PASS;
      end

      if (res.hit) begin
        if (last) begin
          st_next = srchk_pkg::STATE_RESET;
        end else begin
          st_next.verdict_given = 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ipv4_source_route_option_check.sv -----
// ----------------------------------------------------------------------------
// ipv4_source_route_option_check: IPv4 options scan with source-route verdict
// Walks the options area one byte per transfer and gives one verdict per area.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                         meaning
//  --------  ---  ------------------------------  ------------------------------
//  in_ch     in   opt_byte[7:0], bytes_left[5:0]  options byte, bytes remaining
//  out_ch    out  verdict[1:0]                    0 pass, 1 invalid, 2 SR failed
//
//  One byte per cycle sustained while out_ch takes verdicts; a verdict passes
//  through the input register, then the result register, before it can
//  transfer out on out_ch.
//  The scan state loop closes through the combinational srchk_eval, so consecutive
//  bytes of an area never wait on each other.
//  Reset (rst, synchronous) empties both registers and returns the scan to
//  the option type byte of a new area.
//  A stall on out_ch blocks only a byte that gives a verdict; bytes that give
//  none keep flowing.
//
module ipv4_source_route_option_check #(
  parameter int MAX_OPTION_BYTES = srchk_pkg::MAX_OPTION_BYTES
) (
  input logic          clk,
  input logic          rst,
  srchk_in_if.sink     in_ch,
  srchk_out_if.source  out_ch
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic [5:0] in_left;

  // Scan state
  srchk_pkg::state_t    state;
  srchk_pkg::state_t    state_next;
  srchk_pkg::step_res_t res;

  // Result register
  logic                out_valid;
  srchk_pkg::verdict_t out_verdict;

  logic out_free;
  logic fire;

  srchk_eval #(
    .MaxOptionBytes(MAX_OPTION_BYTES)
  ) u_eval (
    .st         (state),
    .opt_byte   (in_byte),
    .bytes_left (in_left),
    .st_next    (state_next),
    .res        (res)
  );

  // Advance the held byte when its verdict, if any, has a free result slot
  assign out_free    = !out_valid || out_ch.ready;
  assign fire        = in_valid && (!res.hit || out_free);
  assign in_ch.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  // Capture payload on transfer only
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.opt_byte;
      in_left <= in_ch.bytes_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srchk_pkg::STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Load a new verdict, or drop the old one once it transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.hit) begin
      out_verdict <= res.verdict;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.verdict = out_verdict;

  // A second verdict for the same area must never come out
  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    state.verdict_given |-> !res.hit)
    else $error("verdict raised after one was already given");

  // Skipping a body only happens inside a sized option
  a_skip_bounds: assert property (@(posedge clk) disable iff (rst)
    state.phase == srchk_pkg::PH_SKIP |->
      (state.bytes_into_option < state.option_length) &&
      (state.option_length >= srchk_pkg::MIN_SR_LEN))
    else $error("skip phase outside option bounds");

  // Pointer phase only follows a checked source-route length
  a_ptr_ctx: assert property (@(posedge clk) disable iff (rst)
    state.phase == srchk_pkg::PH_PTR |->
      state.is_source_route && (state.option_length >= srchk_pkg::MIN_SR_LEN))
    else $error("pointer phase without valid source-route length");

  // A fired verdict lands in the result register
  a_verdict_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && res.hit |=> out_valid && (out_verdict == $past(res.verdict)))
    else $error("verdict not captured");

  // Never overwrite a verdict still waiting to transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !(fire && res.hit))
    else $error("pending verdict overwritten");

endmodule
